[rtl/core/timestamped_sample_interpolator_core_macros.svh]
// Assertion macros for the timestamped sample interpolator core.
`ifndef TIMESTAMPED_SAMPLE_INTERPOLATOR_CORE_MACROS_SVH
`define TIMESTAMPED_SAMPLE_INTERPOLATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TSI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSI_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TSI_ASSERT(label, clk, rst_n, prop, msg)
`define TSI_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[rtl/core/tsi_pkg.sv]
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types and codes for the timestamped sample interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tsi_pkg;
    localparam int TimeW  = 63;
    localparam int CoordW = 32;
    // Interpolation numerator: |delta| (33 bits) times offset (63 bits).
    localparam int ProdW  = 96;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Request to the shared multiply-divide unit.
    typedef struct packed {
        logic                start;
        logic [CoordW:0]     mag;
        logic [TimeW-1:0]    off;
        logic [TimeW-1:0]    span;
    } md_req_t;

    // Status back from the multiply-divide unit.
    typedef struct packed {
        logic                done;
        logic                busy;
        logic [CoordW:0]     quot;
        logic                rem_nz;
    } md_rsp_t;
endpackage
`default_nettype wire

[rtl/core/tsi_muldiv.sv]
// ----------------------------------------------------------------------------
// tsi_muldiv
// Shared unit: floor(mag * off / span) by shift-add multiply then restoring
// division, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "timestamped_sample_interpolator_core_macros.svh"
module tsi_muldiv
    import tsi_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire md_req_t req,
    output md_rsp_t      rsp
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [ProdW-1:0]  acc_reg, acc_next;
    logic [TimeW-1:0]  mcand_reg, mcand_next;
    logic [CoordW:0]   mplier_reg, mplier_next;
    logic [TimeW-1:0]  span_reg, span_next;
    logic [TimeW:0]    rem_reg, rem_next;
    logic [TimeW:0]    rem_sh;
    logic [ProdW-1:0]  mcand_sh;

    always_comb
    begin
        rem_sh   = '0;
        mcand_sh = {{(ProdW-TimeW){1'b0}}, mcand_reg} << cnt_reg;
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        span_next   = span_reg;
        rem_next    = rem_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    state_next  = S_MUL;
                    cnt_next    = '0;
                    acc_next    = '0;
                    mcand_next  = req.off;
                    mplier_next = req.mag;
                    span_next   = req.span;
                end
            end
            S_MUL:
            begin
                // One multiplier bit per cycle: add the shifted offset.
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_sh;
                mplier_next = mplier_reg >> 1;
                if (cnt_reg == 7'(CoordW))
                begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                    rem_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            S_DIV:
            begin
                // One quotient bit per cycle; quotient shifts into acc.
                rem_sh = {rem_reg[TimeW-1:0], acc_reg[ProdW-1]};
                if (rem_sh >= {1'b0, span_reg})
                begin
                    rem_next = rem_sh - {1'b0, span_reg};
                    acc_next = {acc_reg[ProdW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    acc_next = {acc_reg[ProdW-2:0], 1'b0};
                end
                if (cnt_reg == 7'(ProdW-1))
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        span_reg   <= span_next;
        rem_reg    <= rem_next;
    end

    assign rsp.done   = (state_reg == S_DONE);
    assign rsp.busy   = (state_reg != S_IDLE);
    assign rsp.quot   = acc_reg[CoordW:0];
    assign rsp.rem_nz = (rem_reg != '0);

    `TSI_ASSERT(a_done_once, clk, rst_n, rsp.done |=> !rsp.done, "done held two cycles")
    `TSI_ASSERT(a_start_idle, clk, rst_n, (state_reg == S_MUL && cnt_reg == '0) |-> $past(req.start), "mul without start")
    `TSI_ASSERT_NEVER(a_cnt_rng, clk, rst_n, cnt_reg > 7'(ProdW-1), "counter out of range")
endmodule
`default_nettype wire

[rtl/core/timestamped_sample_interpolator_core.sv]
// ----------------------------------------------------------------------------
// timestamped_sample_interpolator_core
// Time-sorted sample table with binary-search lookup and linear interpolation.
// ----------------------------------------------------------------------------
// One word in gives one word out. A load, clear or unused kind goes from the
// accepting state straight to the output state. A query reads the first and
// last entries, then runs a binary search of up to log2(TABLE_DEPTH)+1
// probes, each a registered memory read, then fetches and checks the two
// neighbors. An interpolating query then makes three passes of the shared
// multiply-divide unit, each with a start, 33 multiply steps, 96 divide steps
// and a done state. The result word is held until it is taken. The table is
// not cleared after reset; an entry count bounds every read. The block takes
// one word at a time.
`timescale 1ns / 1ps
`default_nettype none
`include "timestamped_sample_interpolator_core_macros.svh"
module timestamped_sample_interpolator_core
    import tsi_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: stamp_ns[62:0], east_mm[94:63], north_mm[126:95], up_mm[158:127],
    // fix_ok[159]
    input  wire logic [159:0] s_tdata,
    // tuser: kind[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: ok[0], east_out[32:1], north_out[64:33], up_out[96:65], zero pad
    output logic [103:0]      m_tdata
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = TimeW + 3*CoordW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_LAST  = 4'd2;
    localparam logic [3:0] S_PROBE = 4'd3;
    localparam logic [3:0] S_PWAIT = 4'd4;
    localparam logic [3:0] S_RDHI  = 4'd5;
    localparam logic [3:0] S_RDLO  = 4'd6;
    localparam logic [3:0] S_CHECK = 4'd7;
    localparam logic [3:0] S_LERP  = 4'd8;
    localparam logic [3:0] S_LWAIT = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_RDW   = 4'd11;

    // Table memory: time, east, north, up, valid packed per entry.
    logic [EW-1:0] mem [TABLE_DEPTH];
    logic [EW-1:0] rd_q;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] raddr_reg;
    logic          wr_en;

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [TimeW-1:0]  t_reg, t_next;
    logic [CW-1:0]     first_reg, first_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [TimeW-1:0]  t0_reg, t0_next;
    logic [EW-1:0]     hi_reg, hi_next;
    logic [EW-1:0]     lo_reg, lo_next;
    logic [1:0]        axis_reg, axis_next;
    logic [3*CoordW-1:0] res_reg, res_next;
    logic              ok_reg, ok_next;
    logic [3:0]        after_reg, after_next;
    logic [CW-1:0]     half;
    logic [CW-1:0]     probe;

    md_req_t req;
    md_rsp_t rsp;

    logic [TimeW-1:0]  tlo, thi, span, off;
    logic signed [CoordW:0] vlo, vhi, dlt;
    logic signed [CoordW+1:0] sum;

    assign half  = len_reg >> 1;
    assign probe = first_reg + half;

    // Interpolation operands from the lower and upper samples.
    always_comb
    begin
        tlo  = lo_reg[TimeW-1:0];
        thi  = hi_reg[TimeW-1:0];
        span = thi - tlo;
        off  = (t_reg <= tlo) ? '0 : (t_reg - tlo);
        if (off > span)
            off = span;
        vlo = {lo_reg[TimeW+CoordW*(axis_reg+1)-1], lo_reg[TimeW+CoordW*axis_reg +: CoordW]};
        vhi = {hi_reg[TimeW+CoordW*(axis_reg+1)-1], hi_reg[TimeW+CoordW*axis_reg +: CoordW]};
        dlt = vhi - vlo;
        if (dlt[CoordW])
            sum = {vlo[CoordW], vlo} - {1'b0, rsp.quot} - {{(CoordW+1){1'b0}}, rsp.rem_nz};
        else
            sum = {vlo[CoordW], vlo} + {1'b0, rsp.quot};
        req.start = (state_reg == S_LERP);
        req.mag   = dlt[CoordW] ? (CoordW+1)'(-dlt) : dlt;
        req.off   = off;
        req.span  = span;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        t_next     = t_reg;
        first_next = first_reg;
        len_next   = len_reg;
        t0_next    = t0_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        axis_next  = axis_reg;
        res_next   = res_reg;
        ok_next    = ok_reg;
        after_next = after_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    t_next   = s_tdata[TimeW-1:0];
                    ok_next  = 1'b0;
                    res_next = '0;
                    state_next = S_OUT;
                    if (s_tuser == KIND_LOAD)
                    begin
                        if (count_reg < CW'(TABLE_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                            ok_next    = 1'b1;
                        end
                    end
                    else if (s_tuser == KIND_CLEAR)
                        count_next = '0;
                    else if (s_tuser == KIND_QUERY && count_reg != '0)
                    begin
                        // Read the first entry.
                        state_next = S_RDW;
                        after_next = S_FIRST;
                    end
                end
            end
            S_RDW:
            begin
                // Keep the pending address so the read data stays put.
                rd_addr    = raddr_reg;
                state_next = after_reg;
            end
            S_FIRST:
            begin
                t0_next = rd_q[TimeW-1:0];
                lo_next = rd_q;
                rd_addr = AW'(count_reg - 1'b1);
                state_next = S_RDW;
                after_next = S_LAST;
            end
            S_LAST:
            begin
                if (t_reg < t0_reg || t_reg > rd_q[TimeW-1:0])
                    state_next = S_OUT;
                else
                begin
                    first_next = '0;
                    len_next   = count_reg;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (len_reg == '0)
                begin
                    rd_addr    = AW'(first_reg);
                    state_next = S_RDW;
                    after_next = S_RDHI;
                end
                else
                begin
                    rd_addr    = AW'(probe);
                    state_next = S_PWAIT;
                end
            end
            S_PWAIT:
            begin
                // Probe data is in rd_q now; narrow the search range.
                state_next = S_PROBE;
                if (rd_q[TimeW-1:0] < t_reg)
                begin
                    first_next = probe + 1'b1;
                    len_next   = len_reg - half - 1'b1;
                end
                else
                    len_next = half;
            end
            S_RDHI:
            begin
                hi_next = rd_q;
                if (first_reg == '0)
                begin
                    if (rd_q[EW-1])
                    begin
                        ok_next  = 1'b1;
                        res_next = rd_q[TimeW +: 3*CoordW];
                    end
                    state_next = S_OUT;
                end
                else if (first_reg >= count_reg)
                    state_next = S_OUT;
                else
                begin
                    rd_addr    = AW'(first_reg - 1'b1);
                    state_next = S_RDW;
                    after_next = S_RDLO;
                end
            end
            S_RDLO:
            begin
                lo_next    = rd_q;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (lo_reg[EW-1] && hi_reg[EW-1])
                begin
                    ok_next  = 1'b1;
                    res_next = lo_reg[TimeW +: 3*CoordW];
                    if (hi_reg[TimeW-1:0] > lo_reg[TimeW-1:0])
                    begin
                        axis_next  = '0;
                        state_next = S_LERP;
                    end
                    else
                        state_next = S_OUT;
                end
                else
                    state_next = S_OUT;
            end
            S_LERP:
            begin
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (rsp.done)
                begin
                    res_next[CoordW*axis_reg +: CoordW] = sum[CoordW-1:0];
                    if (axis_reg == 2'd2)
                        state_next = S_OUT;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_LERP;
                    end
                end
            end
            S_OUT:
            begin
                if (m_tready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Table write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(count_reg)] <= {s_tdata[159], s_tdata[158:0]};
        rd_q      <= mem[rd_addr];
        raddr_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        first_reg <= first_next;
        len_reg   <= len_next;
        t0_reg    <= t0_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        axis_reg  <= axis_next;
        res_reg   <= res_next;
        ok_reg    <= ok_next;
        after_reg <= after_next;
    end

    tsi_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {7'd0, res_reg[3*CoordW-1:2*CoordW], res_reg[2*CoordW-1:CoordW],
                       res_reg[CoordW-1:0], ok_reg};

    `TSI_ASSERT_NEVER(a_cnt_max, clk, rst_n, count_reg > CW'(TABLE_DEPTH), "count past depth")
    `TSI_ASSERT(a_lerp_ok, clk, rst_n, (state_reg == S_LERP) |-> ok_reg, "lerp without ok")
    `TSI_ASSERT(a_md_idle, clk, rst_n, (state_reg == S_LERP) |-> !rsp.busy, "unit busy at start")
    `TSI_ASSERT(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
endmodule
`default_nettype wire
